@@ hw/rtl/tcf_pkg.sv @@
package tcf_pkg;

	localparam int TAG_W          = 16;
	localparam int TYPE_W         = 8;
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_STAMP_BITS  = 16;

	localparam logic [TYPE_W-1:0] TYPE_DOG_LO = 8'h64;
	localparam logic [TYPE_W-1:0] TYPE_DOG_UP = 8'h44;

	typedef enum logic [1:0] {
		ACT_ENQ     = 2'd0,
		ACT_DEQ_ANY = 2'd1,
		ACT_DEQ_DOG = 2'd2,
		ACT_DEQ_CAT = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

@@ hw/rtl/tcf_queue.sv @@
module tcf_queue import tcf_pkg::*; #(
	parameter int DEPTH   = DEF_QUEUE_DEPTH,
	parameter int ENTRY_W = TAG_W + TYPE_W + DEF_STAMP_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  q_ctl_t             ctl,
	input  logic [ENTRY_W-1:0] wr_entry,
	output logic [ENTRY_W-1:0] head_entry,
	output q_stat_t            stat
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW:0]   DEPTH_F  = (AW+1)'(DEPTH);
	localparam logic [AW+1:0] DEPTH_S  = (AW+2)'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [AW-1:0]      head_q;
	logic [AW:0]        fill_q;
	logic [ENTRY_W-1:0] head_data_q;
	logic [AW+1:0]      wr_sum;
	logic [AW-1:0]      wr_ptr;
	logic [AW-1:0]      head_inc;
	logic [AW-1:0]      head_nxt;

	always_comb begin
		wr_sum = (AW+2)'(head_q) + (AW+2)'(fill_q);
		if (wr_sum >= DEPTH_S) begin
			wr_sum = wr_sum - DEPTH_S;
		end
		wr_ptr   = wr_sum[AW-1:0];
		head_inc = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
		head_nxt = ctl.pop ? head_inc : head_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else begin
			head_q <= head_nxt;
			if (ctl.push && !ctl.pop) begin
				fill_q <= fill_q + (AW+1)'(1);
			end else if (ctl.pop && !ctl.push) begin
				fill_q <= fill_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_ptr] <= wr_entry;
		end
	end

	// head entry kept registered; bypass when the write lands on the next head
	always_ff @(posedge clk) begin
		if (ctl.push && (wr_ptr == head_nxt)) begin
			head_data_q <= wr_entry;
		end else begin
			head_data_q <= mem[head_nxt];
		end
	end

	assign head_entry = head_data_q;
	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == DEPTH_F);

endmodule

@@ hw/rtl/two_class_fifo_oldest_first_core.sv @@
// Two-class FIFO with oldest-first dequeue. Items whose type byte is 'd' or 'D'
// go to the dog queue, all others to the cat queue; each entry keeps its tag,
// type byte and an arrival stamp from a wrapping counter. Every accepted beat
// yields exactly one result beat. One beat is accepted per cycle while the
// result side does not stall; each beat passes the input register, then the
// result register. The head compare and pointer update keep up with this
// rate because each queue's head entry sits in a register that is refilled
// from the queue memory as the head moves.
module two_class_fifo_oldest_first_core import tcf_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int STAMP_BITS  = DEF_STAMP_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [1:0]            action,
	input  logic [TAG_W-1:0]      item_tag,
	input  logic [TYPE_W-1:0]     animal_type,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [1:0]            status,
	output logic [TAG_W-1:0]      out_tag,
	output logic [TYPE_W-1:0]     out_type,
	output logic [STAMP_BITS-1:0] out_stamp,
	output logic                  from_dog
);

	localparam int ENTRY_W = TAG_W + TYPE_W + STAMP_BITS;

	logic                  v_s1;
	action_t               act_s1;
	logic [TAG_W-1:0]      tag_s1;
	logic [TYPE_W-1:0]     type_s1;
	logic [STAMP_BITS-1:0] ctr_q;

	logic                  res_v_q;
	status_t               status_q;
	logic [TAG_W-1:0]      tag_q;
	logic [TYPE_W-1:0]     type_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic                  dog_q;

	logic                  adv;
	logic                  accept;
	q_ctl_t                dog_ctl, cat_ctl;
	q_stat_t               dog_stat, cat_stat;
	logic [ENTRY_W-1:0]    dog_head, cat_head, wr_entry;
	logic [STAMP_BITS-1:0] age_diff;

	logic                  is_dog;
	logic                  tgt_full;
	logic                  take_dog, take_cat;
	logic                  enq_ok;
	status_t               status_d;
	logic [ENTRY_W-1:0]    sel_entry;
	logic [TAG_W-1:0]      tag_d;
	logic [TYPE_W-1:0]     type_d;
	logic [STAMP_BITS-1:0] stamp_d;
	logic                  dog_d;

	assign adv        = v_s1 && (!res_v_q || !result_stall);
	assign item_stall = v_s1 && !adv;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1  <= action_t'(action);
			tag_s1  <= item_tag;
			type_s1 <= animal_type;
		end
	end

	always_comb begin
		is_dog   = (type_s1 == TYPE_DOG_LO) || (type_s1 == TYPE_DOG_UP);
		tgt_full = is_dog ? dog_stat.full : cat_stat.full;
		age_diff = dog_head[STAMP_BITS-1:0] - cat_head[STAMP_BITS-1:0];
		take_dog = 1'b0;
		take_cat = 1'b0;
		enq_ok   = 1'b0;
		status_d = ST_OK;
		tag_d    = '0;
		type_d   = '0;
		stamp_d  = '0;
		dog_d    = 1'b0;
		case (act_s1)
			ACT_ENQ: begin
				dog_d    = is_dog;
				stamp_d  = ctr_q;
				enq_ok   = !tgt_full;
				status_d = tgt_full ? ST_FULL : ST_OK;
			end
			ACT_DEQ_DOG: begin
				take_dog = !dog_stat.empty;
			end
			ACT_DEQ_CAT: begin
				take_cat = !cat_stat.empty;
			end
			ACT_DEQ_ANY: begin
				if (dog_stat.empty) begin
					take_cat = !cat_stat.empty;
				end else if (cat_stat.empty) begin
					take_dog = 1'b1;
				end else begin
					take_dog = age_diff[STAMP_BITS-1];
					take_cat = !age_diff[STAMP_BITS-1];
				end
			end
			default: begin
				status_d = ST_EMPTY;
			end
		endcase
		sel_entry = take_dog ? dog_head : cat_head;
		if (act_s1 != ACT_ENQ) begin
			dog_d = take_dog || (act_s1 == ACT_DEQ_DOG);
			if (take_dog || take_cat) begin
				tag_d   = sel_entry[ENTRY_W-1 -: TAG_W];
				type_d  = sel_entry[STAMP_BITS +: TYPE_W];
				stamp_d = sel_entry[STAMP_BITS-1:0];
			end else begin
				status_d = ST_EMPTY;
			end
		end
	end

	assign wr_entry     = {tag_s1, type_s1, ctr_q};
	assign dog_ctl.push = adv && enq_ok && is_dog;
	assign cat_ctl.push = adv && enq_ok && !is_dog;
	assign dog_ctl.pop  = adv && take_dog;
	assign cat_ctl.pop  = adv && take_cat;

	tcf_queue #(
		.DEPTH   (QUEUE_DEPTH),
		.ENTRY_W (ENTRY_W)
	) u_dog_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (dog_ctl),
		.wr_entry   (wr_entry),
		.head_entry (dog_head),
		.stat       (dog_stat)
	);

	tcf_queue #(
		.DEPTH   (QUEUE_DEPTH),
		.ENTRY_W (ENTRY_W)
	) u_cat_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (cat_ctl),
		.wr_entry   (wr_entry),
		.head_entry (cat_head),
		.stat       (cat_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q   <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (adv && enq_ok) begin
				ctr_q <= ctr_q + STAMP_BITS'(1);
			end
			if (adv) begin
				res_v_q <= 1'b1;
			end else if (!result_stall) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= status_d;
			tag_q    <= tag_d;
			type_q   <= type_d;
			stamp_q  <= stamp_d;
			dog_q    <= dog_d;
		end
	end

	assign result_valid = res_v_q;
	assign status       = status_q;
	assign out_tag      = tag_q;
	assign out_type     = type_q;
	assign out_stamp    = stamp_q;
	assign from_dog     = dog_q;

	a_one_queue_per_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({dog_ctl.push, dog_ctl.pop, cat_ctl.push, cat_ctl.pop}) <= 1)
		else $error("more than one queue operation in one beat");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(dog_ctl.pop && dog_stat.empty) && !(cat_ctl.pop && cat_stat.empty))
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(dog_ctl.push && dog_stat.full) && !(cat_ctl.push && cat_stat.full))
		else $error("push into full queue");

	a_stamp_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(dog_ctl.push || cat_ctl.push) |=> (ctr_q == $past(ctr_q) + STAMP_BITS'(1)))
		else $error("arrival counter did not advance on enqueue");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_v_q)
		else $error("processed beat produced no result");

endmodule

@@ tb/tcf_outcome_check.sv @@
module tcf_outcome_check import tcf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  logic                      item_stall,
	input  logic [1:0]                action,
	input  logic [TAG_W-1:0]          item_tag,
	input  logic [TYPE_W-1:0]         animal_type,
	input  logic                      result_valid,
	input  logic                      result_stall,
	input  logic [1:0]                status,
	input  logic [TAG_W-1:0]          out_tag,
	input  logic [TYPE_W-1:0]         out_type,
	input  logic [DEF_STAMP_BITS-1:0] out_stamp,
	input  logic                      from_dog,
	output int                        mismatches,
	output int                        owed
);

	localparam int QD    = DEF_QUEUE_DEPTH;
	localparam int SW    = DEF_STAMP_BITS;
	localparam int CAT_Q = 0;
	localparam int DOG_Q = 1;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [TYPE_W-1:0] kind;
		logic [SW-1:0]     stamp;
	} kennel_t;

	typedef struct packed {
		status_t           status;
		logic [TAG_W-1:0]  tag;
		logic [TYPE_W-1:0] kind;
		logic [SW-1:0]     stamp;
		logic              dog;
	} outcome_t;

	kennel_t       pens [2][QD];
	int            head [2];
	int            fill [2];
	logic [SW-1:0] arrival;
	outcome_t      due_outcomes [$];

	function automatic outcome_t shelter_step(action_t act, logic [TAG_W-1:0] tag,
			logic [TYPE_W-1:0] kind);
		outcome_t      r;
		int            q;
		logic [SW-1:0] age_diff;
		r = '0;
		r.status = ST_OK;
		q = -1;
		if (act == ACT_ENQ) begin
			q = (kind == TYPE_DOG_LO || kind == TYPE_DOG_UP) ? DOG_Q : CAT_Q;
			r.dog = (q == DOG_Q);
			r.stamp = arrival;
			if (fill[q] >= QD) begin
				r.status = ST_FULL;
			end else begin
				pens[q][(head[q] + fill[q]) % QD] = '{tag, kind, arrival};
				fill[q]++;
				arrival++;
			end
		end else begin
			case (act)
				ACT_DEQ_DOG: begin
					r.dog = 1'b1;
					if (fill[DOG_Q] != 0) q = DOG_Q;
				end
				ACT_DEQ_CAT: begin
					if (fill[CAT_Q] != 0) q = CAT_Q;
				end
				default: begin
					if (fill[DOG_Q] == 0) begin
						if (fill[CAT_Q] != 0) q = CAT_Q;
					end else if (fill[CAT_Q] == 0) begin
						q = DOG_Q;
					end else begin
						// modular age: negative difference means the dog arrived first
						age_diff = pens[DOG_Q][head[DOG_Q]].stamp - pens[CAT_Q][head[CAT_Q]].stamp;
						q = age_diff[SW-1] ? DOG_Q : CAT_Q;
					end
				end
			endcase
			if (q < 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.tag   = pens[q][head[q]].tag;
				r.kind  = pens[q][head[q]].kind;
				r.stamp = pens[q][head[q]].stamp;
				r.dog   = (q == DOG_Q);
				head[q] = (head[q] + 1) % QD;
				fill[q]--;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			head = '{0, 0};
			fill = '{0, 0};
			arrival = '0;
			due_outcomes.delete();
			mismatches = 0;
			owed = 0;
		end else begin
			// result side first, so a beat can never match a prediction made this edge
			if (result_valid && !result_stall) begin
				if (due_outcomes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result beat: status %0d tag %h type %h stamp %h dog %b",
							$time, status, out_tag, out_type, out_stamp, from_dog);
				end else begin
					want = due_outcomes.pop_front();
					if (want.status !== status || want.tag !== out_tag || want.kind !== out_type
							|| want.stamp !== out_stamp || want.dog !== from_dog) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result mismatch", $time);
							$display("  expected status %0d tag %h type %h stamp %h dog %b",
								want.status, want.tag, want.kind, want.stamp, want.dog);
							$display("  actual   status %0d tag %h type %h stamp %h dog %b",
								status, out_tag, out_type, out_stamp, from_dog);
						end
					end
				end
			end
			if (item_valid && !item_stall)
				due_outcomes.push_back(shelter_step(action_t'(action), item_tag, animal_type));
			owed = due_outcomes.size();
		end
	end

endmodule

@@ tb/two_class_fifo_oldest_first_core_tb.sv @@
module two_class_fifo_oldest_first_core_tb import tcf_pkg::*; ();

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int BULK_PAIRS  = 100;
	localparam int RAND_ITEMS  = 1200;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      item_valid;
	logic                      item_stall;
	logic [1:0]                action;
	logic [TAG_W-1:0]          item_tag;
	logic [TYPE_W-1:0]         animal_type;
	logic                      result_valid;
	logic                      result_stall;
	logic [1:0]                status;
	logic [TAG_W-1:0]          out_tag;
	logic [TYPE_W-1:0]         out_type;
	logic [DEF_STAMP_BITS-1:0] out_stamp;
	logic                      from_dog;
	int                        mismatches;
	int                        owed;

	bit steady  = 1'b0;
	bit tx_lazy = 1'b1;
	bit rx_lazy = 1'b1;
	bit hold_rx = 1'b0;
	int quiet_cycles = 0;

	two_class_fifo_oldest_first_core i_dut (.*);
	tcf_outcome_check i_check (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [TYPE_W-1:0] pick_type();
		case ($urandom_range(0, 3))
			0:       return TYPE_DOG_LO;
			1:       return TYPE_DOG_UP;
			default: return TYPE_W'($urandom);
		endcase
	endfunction

	task automatic offer(input action_t act, input logic [TAG_W-1:0] tag,
			input logic [TYPE_W-1:0] kind);
		int gap;
		gap = (tx_lazy && !steady) ? $urandom_range(0, 6) : 0;
		repeat (gap) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid  <= 1'b1;
		action      <= act;
		item_tag    <= tag;
		animal_type <= kind;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
	endtask

	// receiver: per-beat random stall, plus one long hold-off on request
	initial begin
		int gap;
		int served;
		served = 0;
		result_stall <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_rx) begin
				hold_rx = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (served % 64 == 0) rx_lazy = $urandom_range(0, 2) != 0;
			gap = (rx_lazy && !steady) ? $urandom_range(0, 6) : 0;
			repeat (gap) begin
				result_stall <= 1'b1;
				@(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			served++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [TYPE_W-1:0] near_miss [10];
		int                enq_pct;
		int                roll;
		action_t           act;
		near_miss = '{8'h00, 8'hFF, 8'h65, 8'h63, 8'h45, 8'h43, 8'hE4, 8'hC4, 8'h24, 8'h04};
		arst_n      <= 1'b0;
		item_valid  <= 1'b0;
		action      <= ACT_ENQ;
		item_tag    <= '0;
		animal_type <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty requests on every dequeue flavor
		offer(ACT_DEQ_ANY, 16'hFFFF, 8'hFF);
		offer(ACT_DEQ_DOG, 16'h0000, 8'h00);
		offer(ACT_DEQ_CAT, 16'h1234, TYPE_DOG_LO);
		// fill the cat queue with near-miss types, last beat hits full
		for (int k = 0; k < DEF_QUEUE_DEPTH + 1; k++)
			offer(ACT_ENQ, (k == 0) ? 16'hFFFF : (k == 1) ? 16'h0000 : TAG_W'($urandom),
				(k < 10) ? near_miss[k] : (TYPE_W'($urandom) | 8'h01));
		offer(ACT_ENQ, 16'hA5A5, TYPE_DOG_LO);
		offer(ACT_ENQ, 16'h5A5A, TYPE_DOG_UP);
		offer(ACT_DEQ_ANY, 16'h0000, 8'h00);
		offer(ACT_DEQ_DOG, 16'h0000, 8'h00);
		offer(ACT_DEQ_DOG, 16'h0000, 8'h00);
		offer(ACT_DEQ_ANY, 16'h0000, 8'h00);

		for (int k = 0; k < 40; k++)
			offer(ACT_DEQ_ANY, TAG_W'($urandom), pick_type());

		// back-to-back enqueue/dequeue pairs with no sender gaps
		steady = 1'b1;
		for (int k = 0; k < BULK_PAIRS; k++) begin
			offer(ACT_ENQ, TAG_W'($urandom), pick_type());
			offer(ACT_DEQ_ANY, TAG_W'($urandom), pick_type());
		end
		steady = 1'b0;

		enq_pct = 50;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0:       enq_pct = 20;
					1:       enq_pct = 50;
					default: enq_pct = 80;
				endcase
				tx_lazy = $urandom_range(0, 3) != 0;
			end
			if (n == 300) hold_rx = 1'b1;
			if (n == 700) wait_drained();
			roll = $urandom_range(0, 99);
			if (roll < enq_pct) begin
				act = ACT_ENQ;
			end else begin
				case ($urandom_range(0, 3))
					0:       act = ACT_DEQ_DOG;
					1:       act = ACT_DEQ_CAT;
					default: act = ACT_DEQ_ANY;
				endcase
			end
			offer(act, TAG_W'($urandom), pick_type());
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && owed == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
